// ----- rtl/glcm_pkg.sv -----
// ----------------------------------------------------------------------------
// glcm_pkg
// Shared widths, codes and helpers of the co-occurrence texture block.
// ----------------------------------------------------------------------------
package glcm_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int LEVEL_BITS = 3;
  localparam int LEVELS     = 1 << LEVEL_BITS;
  localparam int CELL_BITS  = 2 * LEVEL_BITS;
  localparam int CELLS      = LEVELS * LEVELS;
  localparam int COUNT_BITS = 32;
  localparam int WIDTH_BITS = 11;
  localparam int DIR_BITS   = 2;
  localparam int IDX_BITS   = 2;
  localparam int D2_BITS    = 6;

  localparam int ENT_BITS = 48;
  localparam int ENG_BITS = 64;
  localparam int CON_BITS = 32;
  localparam int HOM_BITS = 40;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam logic [WIDTH_BITS-1:0] DEF_IMAGE_WIDTH = 11'd1024;

  // log10(2) in Q32
  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;
  localparam int NORM_STEPS = 31;
  localparam int SQ_STEPS   = 16;
  localparam int ITER_STEPS = 48;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [DIR_BITS-1:0] {
    DIR_HORIZ = 2'd0,
    DIR_VERT  = 2'd1,
    DIR_DIAG  = 2'd2
  } dir_t;

  localparam logic [IDX_BITS-1:0] REG_DIRECTION = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_WIDTH     = 2'd1;

  typedef struct packed {
    logic start;
    logic clear;
  } fu_ctrl_t;

  // squared level difference of a cell
  function automatic logic [D2_BITS-1:0] sq_diff(input logic [CELL_BITS-1:0] k);
    logic [LEVEL_BITS-1:0] i;
    logic [LEVEL_BITS-1:0] j;
    logic [LEVEL_BITS-1:0] d;
    i = k[CELL_BITS-1:LEVEL_BITS];
    j = k[LEVEL_BITS-1:0];
    d = (i > j) ? i - j : j - i;
    return D2_BITS'({3'b000, d} * {3'b000, d});
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

// ----- rtl/glcm_ram.sv -----
// ----------------------------------------------------------------------------
// glcm_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module glcm_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 3
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/glcm_count_store.sv -----
// ----------------------------------------------------------------------------
// glcm_count_store
// Co-occurrence count memory with per-entry valid bits cleared by reset.
// ----------------------------------------------------------------------------
module glcm_count_store (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [glcm_pkg::CELL_BITS-1:0]   raddr,
  output logic [glcm_pkg::COUNT_BITS-1:0]  rdata,
  input  logic                             we,
  input  logic [glcm_pkg::CELL_BITS-1:0]   waddr,
  input  logic [glcm_pkg::COUNT_BITS-1:0]  wdata
);
  import glcm_pkg::*;

  logic [COUNT_BITS-1:0] mem [CELLS];
  logic [CELLS-1:0]      valid;
  logic [COUNT_BITS-1:0] rd_q;
  logic                  vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      vld_q <= valid[raddr];
    end
  end

  // never-written entries read as zero
  assign rdata = vld_q ? rd_q : '0;

endmodule

// ----- rtl/glcm_feature_unit.sv -----
// ----------------------------------------------------------------------------
// glcm_feature_unit
// Per-cell feature terms (log, square, quotient) and the running sums.
// ----------------------------------------------------------------------------
module glcm_feature_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  glcm_pkg::fu_ctrl_t              ctrl,
  input  logic [glcm_pkg::COUNT_BITS-1:0] count,
  input  logic [glcm_pkg::D2_BITS-1:0]    d2,
  output logic                            busy,
  output logic [glcm_pkg::ENT_BITS-1:0]   ent_sum,
  output logic [glcm_pkg::ENG_BITS-1:0]   eng_sum,
  output logic [glcm_pkg::CON_BITS-1:0]   con_sum,
  output logic [glcm_pkg::HOM_BITS-1:0]   hom_sum
);
  import glcm_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_ITER = 5'b00010,
    F_MUL1 = 5'b00100,
    F_MUL2 = 5'b01000,
    F_ACC  = 5'b10000
  } fstate_t;

  localparam logic [ENT_BITS+5:0] ENT_LIMIT = 54'(1) << 47;
  localparam int QUO_BITS = COUNT_BITS + 16;

  fstate_t               state;
  logic [5:0]            step;
  logic [COUNT_BITS-1:0] c;
  logic [D2_BITS-1:0]    dsq;
  logic [31:0]           m;
  logic [4:0]            e;
  logic [15:0]           frac;
  logic [QUO_BITS-1:0]   x;
  logic [QUO_BITS-1:0]   q;
  logic [D2_BITS-1:0]    rem;
  logic [19:0]           lq;
  logic [63:0]           eng_term;
  logic [51:0]           ent_term;
  logic [37:0]           con_term;

  logic [D2_BITS:0]      rem_sh;
  logic [D2_BITS:0]      den;
  logic [63:0]           sq;
  logic [32:0]           sq_sh;
  logic [51:0]           lq_prod;
  logic [53:0]           ent_acc;
  logic [64:0]           eng_acc;
  logic [38:0]           con_acc;
  logic [48:0]           hom_acc;

  always_comb begin
    rem_sh  = {rem, x[QUO_BITS-1]};
    den     = {1'b0, dsq} + 7'd1;
    sq      = 64'(m) * 64'(m);
    sq_sh   = sq[63:31];
    lq_prod = 52'({e, frac}) * 52'(LOG10_2_Q32);
    ent_acc = 54'(ent_sum) + 54'(ent_term);
    eng_acc = 65'(eng_sum) + 65'(eng_term);
    con_acc = 39'(con_sum) + 39'(con_term);
    hom_acc = 49'(hom_sum) + 49'(q);
  end

  assign busy = (state != F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      step    <= '0;
      ent_sum <= '0;
      eng_sum <= '0;
      con_sum <= '0;
      hom_sum <= '0;
    end else begin
      if (ctrl.clear) begin
        ent_sum <= '0;
        eng_sum <= '0;
        con_sum <= '0;
        hom_sum <= '0;
      end
      case (state)
        F_IDLE: begin
          if (ctrl.start) begin
            c     <= count;
            dsq   <= d2;
            m     <= count;
            e     <= 5'd31;
            frac  <= '0;
            x     <= {count, 16'h0000};
            q     <= '0;
            rem   <= '0;
            step  <= '0;
            state <= F_ITER;
          end
        end
        F_ITER: begin
          // restoring divide, one quotient bit a step
          if (rem_sh >= den) begin
            rem <= D2_BITS'(rem_sh - den);
            q   <= {q[QUO_BITS-2:0], 1'b1};
          end else begin
            rem <= rem_sh[D2_BITS-1:0];
            q   <= {q[QUO_BITS-2:0], 1'b0};
          end
          x <= {x[QUO_BITS-2:0], 1'b0};
          // normalize, then one log2 fraction bit per squaring
          if (step < 6'(NORM_STEPS)) begin
            if (!m[31]) begin
              m <= {m[30:0], 1'b0};
              e <= e - 5'd1;
            end
          end else if (step < 6'(NORM_STEPS + SQ_STEPS)) begin
            if (sq_sh[32]) begin
              m    <= sq_sh[32:1];
              frac <= {frac[14:0], 1'b1};
            end else begin
              m    <= sq_sh[31:0];
              frac <= {frac[14:0], 1'b0};
            end
          end
          step <= step + 6'd1;
          if (step == 6'(ITER_STEPS - 1)) begin
            state <= F_MUL1;
          end
        end
        F_MUL1: begin
          lq       <= lq_prod[51:32];
          eng_term <= 64'(c) * 64'(c);
          state    <= F_MUL2;
        end
        F_MUL2: begin
          ent_term <= 52'(c) * 52'(lq);
          con_term <= 38'(c) * 38'(dsq);
          state    <= F_ACC;
        end
        F_ACC: begin
          ent_sum <= (ent_acc > ENT_LIMIT) ? ENT_LIMIT[ENT_BITS-1:0]
                                          : ent_acc[ENT_BITS-1:0];
          eng_sum <= eng_acc[64] ? '1 : eng_acc[63:0];
          con_sum <= (con_acc > 39'(32'hFFFF_FFFF)) ? '1 : con_acc[31:0];
          hom_sum <= (hom_acc > 49'(40'hFF_FFFF_FFFF)) ? '1 : hom_acc[39:0];
          state   <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/glcm_texture_features.sv -----
// ----------------------------------------------------------------------------
// glcm_texture_features
// Gray-level co-occurrence counts over a pixel stream and texture features.
//
//   channel   direction  handshake          word
//   pixel in  input      in_valid/in_stall  pixel, last_pixel
//   result    output     out_valid/out_stall row/col level, count, features
//   config    input      cfg_valid/cfg_ready register index and data
//
// a pixel passes S_IDLE, S_LINE and, when it forms a pair, S_UPD1 and S_UPD2 (line
// store read, then read-modify-write of both count cells over the count memory port).
// the last pixel starts 64 result words, each read, loaded and computed in turn:
// the feature unit spends 48 steps on the log2 and the quotient, then 3 on products/sums.
// reset is synchronous; the count store reads as zero until written.
// a stalled result holds; pixels are taken again once the last word is loaded.
// ----------------------------------------------------------------------------
module glcm_texture_features #(
  parameter int MAX_WIDTH = glcm_pkg::DEF_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [glcm_pkg::PIXEL_BITS-1:0]  pixel,
  input  logic                             last_pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [glcm_pkg::LEVEL_BITS-1:0]  row_level,
  output logic [glcm_pkg::LEVEL_BITS-1:0]  col_level,
  output logic [glcm_pkg::COUNT_BITS-1:0]  pair_count,
  output logic                             final_res,
  output logic signed [glcm_pkg::ENT_BITS-1:0] entropy,
  output logic [glcm_pkg::ENG_BITS-1:0]    energy,
  output logic [glcm_pkg::CON_BITS-1:0]    contrast,
  output logic [glcm_pkg::HOM_BITS-1:0]    homogeneity,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [glcm_pkg::IDX_BITS-1:0]    cfg_index,
  input  logic [glcm_pkg::WIDTH_BITS-1:0]  cfg_data
);
  import glcm_pkg::*;

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int LINE_DEPTH = 2 << COL_BITS;
  localparam int CMP_BITS   = (COL_BITS + 1 > WIDTH_BITS) ? COL_BITS + 1 : WIDTH_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LINE = 7'b0000010,
    S_UPD1 = 7'b0000100,
    S_UPD2 = 7'b0001000,
    E_READ = 7'b0010000,
    E_LOAD = 7'b0100000,
    E_CALC = 7'b1000000
  } state_t;

  state_t                state;
  logic [DIR_BITS-1:0]   direction;
  logic [WIDTH_BITS-1:0] image_width;
  logic [COL_BITS-1:0]   col;
  logic                  row_slot;
  logic                  past_first_row;
  logic [LEVEL_BITS-1:0] left_level;
  logic [LEVEL_BITS-1:0] upper_left_level;
  logic [LEVEL_BITS-1:0] cur_lvl;
  logic [LEVEL_BITS-1:0] left_nb;
  logic [LEVEL_BITS-1:0] ul_nb;
  logic                  left_ok;
  logic                  pfr;
  logic                  last_flag;
  logic [CELL_BITS-1:0]  addr1;
  logic [CELL_BITS-1:0]  addr2;
  logic [COUNT_BITS-1:0] wval1;
  logic [CELL_BITS-1:0]  cell_idx;
  logic [COUNT_BITS-1:0] cnt_hold;

  logic                  accept;
  logic [CMP_BITS-1:0]   w_ext;
  logic [CMP_BITS-1:0]   eff_width;
  logic                  row_end;
  logic [LEVEL_BITS-1:0] lvl;
  logic [LEVEL_BITS-1:0] up_level;
  logic                  pair;
  logic [LEVEL_BITS-1:0] nb;
  logic                  go_emit;
  logic                  out_free;
  logic                  out_load;

  logic [CELL_BITS-1:0]  cs_raddr;
  logic [COUNT_BITS-1:0] cs_rdata;
  logic                  cs_we;
  logic [CELL_BITS-1:0]  cs_waddr;
  logic [COUNT_BITS-1:0] cs_wdata;
  logic [COUNT_BITS-1:0] upd2_old;

  fu_ctrl_t              fu_ctrl;
  logic                  fu_busy;
  logic [ENT_BITS-1:0]   ent_sum;
  logic [ENG_BITS-1:0]   eng_sum;
  logic [CON_BITS-1:0]   con_sum;
  logic [HOM_BITS-1:0]   hom_sum;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign lvl       = pixel[PIXEL_BITS-1 -: LEVEL_BITS];
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == E_CALC) && !fu_busy && out_free;

  always_comb begin
    w_ext = CMP_BITS'(image_width);
    if (w_ext == '0) begin
      eff_width = CMP_BITS'(1);
    end else if (w_ext > CMP_BITS'(MAX_WIDTH)) begin
      eff_width = CMP_BITS'(MAX_WIDTH);
    end else begin
      eff_width = w_ext;
    end
    row_end = (CMP_BITS'(col) + CMP_BITS'(1)) >= eff_width;
  end

  glcm_ram #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (LEVEL_BITS)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr ({row_slot, col}),
    .wdata (lvl),
    .raddr ({~row_slot, col}),
    .rdata (up_level)
  );

  // neighbor choice once the row above is back from the line store
  always_comb begin
    case (direction)
      DIR_HORIZ: begin
        pair = left_ok;
        nb   = left_nb;
      end
      DIR_VERT: begin
        pair = pfr;
        nb   = up_level;
      end
      DIR_DIAG: begin
        pair = pfr && left_ok;
        nb   = ul_nb;
      end
      default: begin
        pair = 1'b0;
        nb   = left_nb;
      end
    endcase
  end

  assign go_emit = last_flag &&
                   (((state == S_LINE) && !pair) || (state == S_UPD2));

  // forward the first write when both cells are the same
  assign upd2_old = (addr1 == addr2) ? wval1 : cs_rdata;

  always_comb begin
    cs_raddr = cell_idx;
    cs_we    = 1'b0;
    cs_waddr = addr1;
    cs_wdata = '0;
    case (state)
      S_LINE: begin
        cs_raddr = {cur_lvl, nb};
      end
      S_UPD1: begin
        cs_raddr = addr2;
        cs_we    = 1'b1;
        cs_waddr = addr1;
        cs_wdata = sat_inc(cs_rdata);
      end
      S_UPD2: begin
        cs_we    = 1'b1;
        cs_waddr = addr2;
        cs_wdata = sat_inc(upd2_old);
      end
      E_LOAD: begin
        // clear the cell as it is read out
        cs_we    = 1'b1;
        cs_waddr = cell_idx;
        cs_wdata = '0;
      end
      default: begin
        cs_raddr = cell_idx;
      end
    endcase
  end

  glcm_count_store u_counts (
    .clk   (clk),
    .rst   (rst),
    .raddr (cs_raddr),
    .rdata (cs_rdata),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (cs_wdata)
  );

  assign fu_ctrl.start = (state == E_LOAD);
  assign fu_ctrl.clear = go_emit;

  glcm_feature_unit u_features (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (fu_ctrl),
    .count   (cs_rdata),
    .d2      (sq_diff(cell_idx)),
    .busy    (fu_busy),
    .ent_sum (ent_sum),
    .eng_sum (eng_sum),
    .con_sum (con_sum),
    .hom_sum (hom_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= DIR_HORIZ;
      image_width <= DEF_IMAGE_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_DIRECTION) begin
        direction <= cfg_data[DIR_BITS-1:0];
      end else if (cfg_index == REG_WIDTH) begin
        image_width <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      col              <= '0;
      row_slot         <= 1'b0;
      past_first_row   <= 1'b0;
      left_level       <= '0;
      upper_left_level <= '0;
      last_flag        <= 1'b0;
      cell_idx         <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur_lvl    <= lvl;
            left_nb    <= left_level;
            ul_nb      <= upper_left_level;
            left_ok    <= (col != '0);
            pfr        <= past_first_row;
            last_flag  <= last_pixel;
            left_level <= lvl;
            if (row_end) begin
              col            <= '0;
              row_slot       <= ~row_slot;
              past_first_row <= 1'b1;
            end else begin
              col <= col + 1'b1;
            end
            state <= S_LINE;
          end
        end
        S_LINE: begin
          upper_left_level <= up_level;
          addr1 <= {cur_lvl, nb};
          addr2 <= {nb, cur_lvl};
          if (pair) begin
            state <= S_UPD1;
          end else if (last_flag) begin
            state <= E_READ;
          end else begin
            state <= S_IDLE;
          end
        end
        S_UPD1: begin
          wval1 <= sat_inc(cs_rdata);
          state <= S_UPD2;
        end
        S_UPD2: begin
          state <= last_flag ? E_READ : S_IDLE;
        end
        E_READ: begin
          state <= E_LOAD;
        end
        E_LOAD: begin
          cnt_hold <= cs_rdata;
          state    <= E_CALC;
        end
        E_CALC: begin
          if (out_load) begin
            row_level  <= cell_idx[CELL_BITS-1:LEVEL_BITS];
            col_level  <= cell_idx[LEVEL_BITS-1:0];
            pair_count <= cnt_hold;
            if (cell_idx == CELL_BITS'(CELLS - 1)) begin
              final_res   <= 1'b1;
              entropy     <= ENT_BITS'(0) - ent_sum;
              energy      <= eng_sum;
              contrast    <= con_sum;
              homogeneity <= hom_sum;
              cell_idx    <= '0;
              state       <= S_IDLE;
            end else begin
              final_res   <= 1'b0;
              entropy     <= '0;
              energy      <= '0;
              contrast    <= '0;
              homogeneity <= '0;
              cell_idx    <= cell_idx + 1'b1;
              state       <= E_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // new image starts at the top-left corner
      if (go_emit) begin
        col            <= '0;
        row_slot       <= 1'b0;
        past_first_row <= 1'b0;
        cell_idx       <= '0;
        last_flag      <= 1'b0;
      end
    end
  end

endmodule

// ----- tb/tb_glcm_texture_features.sv -----
// ----------------------------------------------------------------------------
// tb_glcm_texture_features
// Streams small images through the co-occurrence block under random gaps and
// stalls, predicts every cell word and the feature word, and compares them.
// ----------------------------------------------------------------------------
module tb_glcm_texture_features;
  import glcm_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int SETTLE      = 20;
  localparam int PIXEL_GOAL  = 360;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] row;
    logic [LEVEL_BITS-1:0] col;
    logic [COUNT_BITS-1:0] count;
    logic                  fin;
    logic [ENT_BITS-1:0]   ent;
    logic [ENG_BITS-1:0]   eng;
    logic [CON_BITS-1:0]   con;
    logic [HOM_BITS-1:0]   hom;
  } cell_word_t;

  class glcm_scoreboard;
    cell_word_t             expected[$];
    int                     errors;
    logic [DIR_BITS-1:0]    dir;
    logic [WIDTH_BITS-1:0]  width;
    logic [COUNT_BITS-1:0]  counts[CELLS];
    logic [LEVEL_BITS-1:0]  line_mem[2][DEF_MAX_WIDTH];
    int                     column;
    int                     slot;
    bit                     above_ok;

    function new();
      errors = 0;
      dir = DIR_HORIZ;
      width = DEF_IMAGE_WIDTH;
      foreach (counts[k]) counts[k] = '0;
      column = 0;
      slot = 0;
      above_ok = 0;
    endfunction

    function void set_reg(logic [IDX_BITS-1:0] idx, logic [WIDTH_BITS-1:0] val);
      if (idx == REG_DIRECTION) dir = val[DIR_BITS-1:0];
      else if (idx == REG_WIDTH) width = val;
    endfunction

    function void bump(int a, int b);
      int k;
      k = a * LEVELS + b;
      if (counts[k] != COUNT_MAX) counts[k] = counts[k] + 1;
    endfunction

    // log10 in Q16 via log2 with mantissa squaring
    function logic [63:0] log10_q16(logic [63:0] c);
      int e;
      logic [63:0] t, m, r;
      e = 0;
      t = c;
      while (t > 1) begin
        t = t >> 1;
        e++;
      end
      m = (e <= 31) ? (c << (31 - e)) : (c >> (e - 31));
      r = 64'(e) << 16;
      for (int b = 15; b >= 0; b--) begin
        m = (m * m) >> 31;
        if (m >= (64'd1 << 32)) begin
          m = m >> 1;
          r[b] = 1'b1;
        end
      end
      return (r * 64'(LOG10_2_Q32)) >> 32;
    endfunction

    function void emit_image();
      logic [63:0] ent, con, hom, c, d, d2, lq, lim;
      logic [64:0] eng;
      cell_word_t w;
      ent = 0; eng = 0; con = 0; hom = 0;
      lim = 64'd1 << 47;
      for (int k = 0; k < CELLS; k++) begin
        c = 64'(counts[k]);
        d = (k / LEVELS > k % LEVELS) ? 64'(k / LEVELS - k % LEVELS)
                                      : 64'(k % LEVELS - k / LEVELS);
        d2 = d * d;
        if (c >= 2 && ent < lim) begin
          lq = log10_q16(c);
          if (lq != 0 && c > (lim - ent) / lq) ent = lim;
          else ent = ent + c * lq;
        end
        eng = eng + 65'(c * c);
        if (eng[64]) eng = {1'b0, {64{1'b1}}};
        con = con + d2 * c;
        if (con > 64'hFFFF_FFFF) con = 64'hFFFF_FFFF;
        hom = hom + (c << 16) / (1 + d2);
        if (hom > 64'hFF_FFFF_FFFF) hom = 64'hFF_FFFF_FFFF;
        w = '0;
        w.row = LEVEL_BITS'(k / LEVELS);
        w.col = LEVEL_BITS'(k % LEVELS);
        w.count = counts[k];
        if (k == CELLS - 1) begin
          w.fin = 1'b1;
          w.ent = ENT_BITS'(64'd0 - ent);
          w.eng = eng[63:0];
          w.con = con[31:0];
          w.hom = hom[39:0];
        end
        expected.push_back(w);
      end
      foreach (counts[k]) counts[k] = '0;
      column = 0;
      slot = 0;
      above_ok = 0;
    endfunction

    function void note_pixel(logic [PIXEL_BITS-1:0] px, logic last);
      int w, lvl, col, up;
      w = width;
      if (w == 0) w = 1;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      lvl = px >> 5;
      col = column;
      up = slot ^ 1;
      if (dir == DIR_HORIZ && col >= 1) begin
        bump(lvl, line_mem[slot][col-1]);
        bump(line_mem[slot][col-1], lvl);
      end else if (dir == DIR_VERT && above_ok) begin
        bump(lvl, line_mem[up][col]);
        bump(line_mem[up][col], lvl);
      end else if (dir == DIR_DIAG && above_ok && col >= 1) begin
        bump(lvl, line_mem[up][col-1]);
        bump(line_mem[up][col-1], lvl);
      end
      line_mem[slot][col] = LEVEL_BITS'(lvl);
      if (col + 1 >= w) begin
        column = 0;
        slot = slot ^ 1;
        above_ok = 1;
      end else begin
        column = col + 1;
      end
      if (last) emit_image();
    endfunction

    function void check(cell_word_t got);
      cell_word_t exp_w;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word row %0d col %0d count %0d", got.row, got.col, got.count);
        return;
      end
      exp_w = expected.pop_front();
      if (got !== exp_w) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp r%0d c%0d n%0d f%0d ent %h eng %h con %h hom %h",
                   exp_w.row, exp_w.col, exp_w.count, exp_w.fin, exp_w.ent, exp_w.eng,
                   exp_w.con, exp_w.hom);
          $display("         got r%0d c%0d n%0d f%0d ent %h eng %h con %h hom %h",
                   got.row, got.col, got.count, got.fin, got.ent, got.eng,
                   got.con, got.hom);
        end
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [PIXEL_BITS-1:0]   pixel;
  logic                    last_pixel;
  logic                    out_valid;
  logic                    out_stall;
  logic [LEVEL_BITS-1:0]   row_level;
  logic [LEVEL_BITS-1:0]   col_level;
  logic [COUNT_BITS-1:0]   pair_count;
  logic                    final_res;
  logic signed [ENT_BITS-1:0] entropy;
  logic [ENG_BITS-1:0]     energy;
  logic [CON_BITS-1:0]     contrast;
  logic [HOM_BITS-1:0]     homogeneity;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [IDX_BITS-1:0]     cfg_index;
  logic [WIDTH_BITS-1:0]   cfg_data;

  glcm_scoreboard sb;
  int cycles = 0;
  int stall_left;
  int pixels_sent;

  glcm_texture_features u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .last_pixel(last_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .row_level(row_level), .col_level(col_level), .pair_count(pair_count),
    .final_res(final_res), .entropy(entropy), .energy(energy),
    .contrast(contrast), .homogeneity(homogeneity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls in runs
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check('{row_level, col_level, pair_count, final_res, entropy, energy,
                 contrast, homogeneity});
  end

  task automatic send_pixel(logic [PIXEL_BITS-1:0] px, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    last_pixel <= last;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(px, last);
    pixels_sent++;
  endtask

  // flat images pile counts into few cells
  task automatic send_image(int npix, bit flat);
    logic [PIXEL_BITS-1:0] base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < npix; i++)
      send_pixel(flat ? (base ^ PIXEL_BITS'($urandom_range(0, 31))) :
                 PIXEL_BITS'($urandom_range(0, 255)), i == npix - 1);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [WIDTH_BITS-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  initial begin
    int w, r;
    sb = new();
    pixels_sent = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    pixel <= '0;
    last_pixel <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DIRECTION;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default width, one row of extremes
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd31, 1'b0);
    send_pixel(8'd32, 1'b1);
    in_valid <= 1'b0;
    send_image(1, 0);
    write_reg(REG_WIDTH, 11'd3);
    for (int d = 0; d < 3; d++) begin
      write_reg(REG_DIRECTION, WIDTH_BITS'(d));
      send_image(9, 0);
    end
    write_reg(REG_DIRECTION, 11'd3);
    send_image(5, 0);
    write_reg(REG_DIRECTION, WIDTH_BITS'(DIR_VERT));
    write_reg(REG_WIDTH, 11'd0);
    send_image(4, 0);
    write_reg(REG_DIRECTION, WIDTH_BITS'(DIR_DIAG));
    write_reg(REG_WIDTH, 11'd2047);
    send_image(6, 0);

    while (pixels_sent < PIXEL_GOAL) begin
      write_reg(REG_DIRECTION,
                WIDTH_BITS'($urandom_range(0, 7) == 0 ? 3 : $urandom_range(0, 2)));
      r = $urandom_range(0, 19);
      if (r == 0) w = 0;
      else if (r == 1) w = 1024;
      else if (r == 2) w = 2047;
      else if (r < 8) w = $urandom_range(9, 40);
      else w = $urandom_range(1, 8);
      write_reg(REG_WIDTH, WIDTH_BITS'(w));
      send_image($urandom_range(1, 40), $urandom_range(0, 3) == 0);
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
